/* rtl/ikepcl_pkg.sv */
// Package for the IKE payload chain locator.
// Holds widths, message layout constants, status codes and the result struct.
// No dependencies.
package ikepcl_pkg;

   localparam int OFFSET_BITS        = 16;
   localparam int LENGTH_BITS        = 16;
   localparam int TYPE_BITS          = 8;
   localparam int FIXED_HEADER_BYTES = 28;
   localparam int FIRST_TYPE_BYTE    = 16;
   localparam int MIN_PAYLOAD_BYTES  = 4;

   localparam logic [OFFSET_BITS-1:0] POS_LIMIT      = {OFFSET_BITS{1'b1}};
   localparam logic [OFFSET_BITS-1:0] FIRST_TYPE_POS = OFFSET_BITS'(FIRST_TYPE_BYTE);
   localparam logic [OFFSET_BITS-1:0] CHAIN_START    = OFFSET_BITS'(FIXED_HEADER_BYTES);
   localparam logic [LENGTH_BITS-1:0] MIN_LENGTH     = LENGTH_BITS'(MIN_PAYLOAD_BYTES);
   localparam logic [TYPE_BITS-1:0]   TARGET_RESET   = TYPE_BITS'(5);
   localparam logic [TYPE_BITS-1:0]   TYPE_NONE      = '0;

   typedef enum logic [1:0] {
      STATUS_FOUND     = 2'd0,
      STATUS_ABSENT    = 2'd1,
      STATUS_MALFORMED = 2'd2
   } status_type;

   // Position inside a generic payload header.
   typedef enum logic [1:0] {
      HDR_WAIT     = 2'd0,
      HDR_RESERVED = 2'd1,
      HDR_LEN_HIGH = 2'd2,
      HDR_LEN_LOW  = 2'd3
   } hdr_step_type;

   typedef struct packed {
      status_type              status;
      logic [OFFSET_BITS-1:0]  payload_offset;
      logic [LENGTH_BITS-1:0]  payload_length;
   } result_type;

endpackage

/* rtl/ikepcl_walker.sv */
// Payload chain walker: per-byte message state and end-of-message verdict.
// Depends on ikepcl_pkg.
module ikepcl_walker
   import ikepcl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           data_byte,
   input  logic                 last_byte,
   input  logic [TYPE_BITS-1:0] target_type,
   output logic                 result_valid,
   output result_type           result
);

   logic [OFFSET_BITS-1:0] byte_position_ff, byte_position_in;
   logic [TYPE_BITS-1:0]   current_type_ff, current_type_in;
   logic [TYPE_BITS-1:0]   pending_type_ff, pending_type_in;
   logic [OFFSET_BITS-1:0] next_header_at_ff, next_header_at_in;
   hdr_step_type           header_index_ff, header_index_in;
   logic [7:0]             length_high_ff, length_high_in;
   logic                   chain_ended_ff, chain_ended_in;
   logic                   found_flag_ff, found_flag_in;
   logic [OFFSET_BITS-1:0] found_offset_ff, found_offset_in;
   logic [LENGTH_BITS-1:0] found_length_ff, found_length_in;
   logic                   malformed_flag_ff, malformed_flag_in;

   logic [LENGTH_BITS-1:0] length_word;
   logic [OFFSET_BITS:0]   next_sum;
   logic [OFFSET_BITS:0]   msg_len;
   logic [OFFSET_BITS:0]   found_end;

   assign length_word = {length_high_ff, data_byte};
   assign next_sum    = {1'b0, next_header_at_ff} + {1'b0, length_word};

   // Next state
   always_comb begin
      byte_position_in  = byte_position_ff;
      current_type_in   = current_type_ff;
      pending_type_in   = pending_type_ff;
      next_header_at_in = next_header_at_ff;
      header_index_in   = header_index_ff;
      length_high_in    = length_high_ff;
      chain_ended_in    = chain_ended_ff;
      found_flag_in     = found_flag_ff;
      found_offset_in   = found_offset_ff;
      found_length_in   = found_length_ff;
      malformed_flag_in = malformed_flag_ff;
      if (step) begin
         if (byte_position_ff == POS_LIMIT) begin
            malformed_flag_in = 1'b1;
         end else begin
            if (byte_position_ff == FIRST_TYPE_POS) begin
               current_type_in = data_byte;
            end
            if (!(chain_ended_ff || found_flag_ff || malformed_flag_ff)) begin
               unique case (header_index_ff)
                  HDR_WAIT: begin
                     if (byte_position_ff == next_header_at_ff) begin
                        if (current_type_in == TYPE_NONE) begin
                           chain_ended_in = 1'b1;
                        end else begin
                           pending_type_in = data_byte;
                           header_index_in = HDR_RESERVED;
                        end
                     end
                  end
                  HDR_RESERVED: header_index_in = HDR_LEN_HIGH;
                  HDR_LEN_HIGH: begin
                     length_high_in  = data_byte;
                     header_index_in = HDR_LEN_LOW;
                  end
                  HDR_LEN_LOW: begin
                     header_index_in = HDR_WAIT;
                     if (length_word < MIN_LENGTH) begin
                        malformed_flag_in = 1'b1;
                     end else if (current_type_in == target_type) begin
                        found_flag_in   = 1'b1;
                        found_offset_in = next_header_at_ff;
                        found_length_in = length_word;
                     end else if (next_sum[OFFSET_BITS]) begin
                        malformed_flag_in = 1'b1;
                     end else begin
                        next_header_at_in = next_sum[OFFSET_BITS-1:0];
                        current_type_in   = pending_type_ff;
                     end
                  end
                  default: header_index_in = HDR_WAIT;
               endcase
            end
            byte_position_in = byte_position_ff + 1'b1;
         end
      end
   end

   // Verdict on the final byte, from the updated state
   always_comb begin
      msg_len   = {1'b0, byte_position_ff} + 1'b1;
      found_end = {1'b0, found_offset_in} + {1'b0, found_length_in};
      result.payload_offset = '0;
      result.payload_length = '0;
      priority if (malformed_flag_in) begin
         result.status = STATUS_MALFORMED;
      end else if (found_flag_in) begin
         if (found_end > msg_len) begin
            result.status = STATUS_MALFORMED;
         end else begin
            result.status         = STATUS_FOUND;
            result.payload_offset = found_offset_in;
            result.payload_length = found_length_in;
         end
      end else if (header_index_in != HDR_WAIT) begin
         result.status = STATUS_MALFORMED;
      end else if (!chain_ended_in && next_header_at_in != CHAIN_START &&
                   {1'b0, next_header_at_in} > msg_len) begin
         result.status = STATUS_MALFORMED;
      end else begin
         result.status = STATUS_ABSENT;
      end
   end

   assign result_valid = step && last_byte;

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         byte_position_ff  <= '0;
         current_type_ff   <= TYPE_NONE;
         pending_type_ff   <= TYPE_NONE;
         next_header_at_ff <= CHAIN_START;
         header_index_ff   <= HDR_WAIT;
         length_high_ff    <= '0;
         chain_ended_ff    <= 1'b0;
         found_flag_ff     <= 1'b0;
         found_offset_ff   <= '0;
         found_length_ff   <= '0;
         malformed_flag_ff <= 1'b0;
      end else begin
         byte_position_ff  <= byte_position_in;
         current_type_ff   <= current_type_in;
         pending_type_ff   <= pending_type_in;
         next_header_at_ff <= next_header_at_in;
         header_index_ff   <= header_index_in;
         length_high_ff    <= length_high_in;
         chain_ended_ff    <= chain_ended_in;
         found_flag_ff     <= found_flag_in;
         found_offset_ff   <= found_offset_in;
         found_length_ff   <= found_length_in;
         malformed_flag_ff <= malformed_flag_in;
      end
   end

endmodule

/* rtl/ikepcl_out_reg.sv */
// Result register for the locator's response channel.
// Depends on ikepcl_pkg.
module ikepcl_out_reg
   import ikepcl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load_valid,
   input  result_type load_data,
   output logic       load_ready,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   // Free when empty or when the held beat leaves this cycle.
   assign load_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load_ready) begin
         valid_in = load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ready && load_valid) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/ike_payload_chain_locator.sv */
// Top level of the IKE payload chain locator.
// Depends on ikepcl_pkg, ikepcl_walker and ikepcl_out_reg.
//
// Usage:
//   req_*  : message bytes in order from byte zero, one beat per byte;
//            req_last_byte marks the final byte of a message.
//   rsp_*  : one beat per message, holding status (found, absent, malformed),
//            the header offset and the length field of the target payload.
//   csr_*  : write of the target payload type (reset value 5, ID).
//            Always ready; write it only while no message is in flight.
// Timing:
//   One byte per cycle while req_ready is high. Each byte updates the walker
//   state at the edge that accepts it; the verdict for the final byte lands in
//   the result register at that same edge, so rsp_valid rises in the cycle
//   after the last byte is accepted.
// Stall:
//   The result register holds one beat. req_ready drops only while that
//   beat is held and rsp_ready is low; bytes then wait on the input side.
// Reset:
//   Synchronous. Clears the walker state, drops the held result and
//   restores the target type.
module ike_payload_chain_locator
   import ikepcl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_last_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [OFFSET_BITS-1:0] rsp_payload_offset,
   output logic [LENGTH_BITS-1:0] rsp_payload_length,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [TYPE_BITS-1:0]   csr_target_type
);

   logic [TYPE_BITS-1:0] target_type_ff, target_type_in;
   logic                 step;
   logic                 result_valid;
   logic                 load_ready;
   result_type           result;
   result_type           rsp_data;

   // Target type register: take every write beat.
   assign csr_ready = 1'b1;

   always_comb begin
      target_type_in = target_type_ff;
      if (csr_valid) begin
         target_type_in = csr_target_type;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_type_ff <= TARGET_RESET;
      end else begin
         target_type_ff <= target_type_in;
      end
   end

   // Advance a byte only when the result register can take a verdict.
   assign req_ready = load_ready;
   assign step      = req_valid && req_ready;

   ikepcl_walker u_walker (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .data_byte    (req_data_byte),
      .last_byte    (req_last_byte),
      .target_type  (target_type_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   ikepcl_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (result_valid),
      .load_data  (result),
      .load_ready (load_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (rsp_data)
   );

   assign rsp_status         = rsp_data.status;
   assign rsp_payload_offset = rsp_data.payload_offset;
   assign rsp_payload_length = rsp_data.payload_length;

endmodule

/* rtl/ikepcl_checker.sv */
// Port-level checks for the IKE payload chain locator, bound to the top level.
// Depends on ikepcl_pkg and ike_payload_chain_locator.
module ikepcl_checker
   import ikepcl_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   req_last_byte,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [1:0]             rsp_status,
   input logic [OFFSET_BITS-1:0] rsp_payload_offset,
   input logic [LENGTH_BITS-1:0] rsp_payload_length
);

   // Reset drops any held result.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result held across reset");

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_payload_offset) && $stable(rsp_payload_length))
      else $error("result beat changed while stalled");

   // Offset and length are zero unless the payload was found.
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_FOUND |->
         rsp_payload_offset == '0 && rsp_payload_length == '0)
      else $error("fields set on a not-found result");

   // A found payload sits in the chain and has a sane length.
   a_found_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FOUND |->
         rsp_payload_offset >= CHAIN_START && rsp_payload_length >= MIN_LENGTH)
      else $error("found payload with bad offset or length");

   // A result is pending only after a final byte; without one, none appears.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid ##1 rsp_valid |-> $past(req_valid && req_ready && req_last_byte))
      else $error("result without a final byte");

endmodule

bind ike_payload_chain_locator ikepcl_checker u_checker (.*);

/* tb/tb_top.sv */
// Self-checking testbench for the IKE payload chain locator (ike_payload_chain_locator).
// Depends on ikepcl_pkg for widths, status codes and the result struct, and on the RTL top.
// Runs a directed message table, then random phases with random idling.
module tb_top;
   import ikepcl_pkg::*;

   localparam int QUIET_LIMIT = 5000;  // cycles with no beat on any port before giving up
   localparam int HOLD_CYCLES = 400;   // long receiver hold-off used to fill the block
   localparam int PHASE_BYTES = 140;
   localparam int PHASE_MSGS  = 2;
   localparam int DRAIN_CYCLES = 8;

   // One row of the directed table: the target to program, the message shape
   // and, where it is obvious, the verdict typed in by hand.
   typedef struct {
      logic [TYPE_BITS-1:0] tgt;
      int                   mlen;
      int                   n;
      logic [7:0]           types [5];
      logic [15:0]          lens [5];
      bit                   typed;
      result_type           verdict;
   } probe_row;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_data_byte = '0;
   logic                   req_last_byte = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [1:0]             rsp_status;
   logic [OFFSET_BITS-1:0] rsp_payload_offset;
   logic [LENGTH_BITS-1:0] rsp_payload_length;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [TYPE_BITS-1:0]   csr_target_type = '0;

   // Predictor state: the chain walker as the block should see it.
   logic [TYPE_BITS-1:0] locate_target = TARGET_RESET;
   int unsigned          walk_pos;
   logic [7:0]           walk_type;
   logic [7:0]           walk_next_type;
   int unsigned          walk_hdr_at;
   hdr_step_type         walk_step;
   logic [7:0]           walk_len_hi;
   bit                   walk_ended;
   bit                   walk_found;
   bit                   walk_bad;
   int unsigned          found_at;
   int unsigned          found_len;

   result_type           verdict_q [$];   // verdicts still owed by the block
   logic [7:0]           msg_bytes [$];   // message being built for the sender
   probe_row             probe_rows [$];

   // Sender-side bookkeeping.
   logic [TYPE_BITS-1:0] target_now = TARGET_RESET;
   bit                   row_typed = 1'b0;
   result_type           row_verdict;
   int                   send_idle_pct = 0;
   int                   recv_stall_pct = 0;
   bit                   hold_req = 1'b0;
   int                   hold_left = 0;

   int                   mismatches = 0;
   int                   msgs_sent = 0;
   int                   bytes_sent = 0;
   int                   cnt_found = 0;
   int                   cnt_absent = 0;
   int                   cnt_malformed = 0;
   int                   quiet_cycles = 0;

   ike_payload_chain_locator i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_payload_length (rsp_payload_length),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_target_type    (csr_target_type)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Return the walker to its idle state between messages.
   function automatic void clear_walk();
      walk_pos       = 0;
      walk_type      = TYPE_NONE;
      walk_next_type = TYPE_NONE;
      walk_hdr_at    = FIXED_HEADER_BYTES;
      walk_step      = HDR_WAIT;
      walk_len_hi    = '0;
      walk_ended     = 1'b0;
      walk_found     = 1'b0;
      walk_bad       = 1'b0;
      found_at       = 0;
      found_len      = 0;
   endfunction

   // Advance the walker by one message byte. Returns 1 with the verdict on
   // the final byte of a message.
   function automatic bit locate_byte(input logic [7:0] d, input logic last,
                                      output result_type v);
      int unsigned p;
      int unsigned msg_len;
      int unsigned plen;
      int unsigned nxt;
      p       = walk_pos;
      msg_len = p + 1;
      // Past the largest offset the message is oversized; freeze the counter.
      if (p >= POS_LIMIT) begin
         walk_bad = 1'b1;
      end else begin
         if (p == FIRST_TYPE_BYTE) walk_type = d;
         if (!(walk_ended || walk_found || walk_bad)) begin
            case (walk_step)
               HDR_WAIT: begin
                  if (p == walk_hdr_at) begin
                     // A zero current type at a header position ends the chain.
                     if (walk_type == TYPE_NONE) begin
                        walk_ended = 1'b1;
                     end else begin
                        walk_next_type = d;
                        walk_step      = HDR_RESERVED;
                     end
                  end
               end
               HDR_RESERVED: walk_step = HDR_LEN_HIGH;
               HDR_LEN_HIGH: begin
                  walk_len_hi = d;
                  walk_step   = HDR_LEN_LOW;
               end
               default: begin
                  plen      = {walk_len_hi, d};
                  walk_step = HDR_WAIT;
                  if (plen < MIN_PAYLOAD_BYTES) begin
                     walk_bad = 1'b1;
                  end else if (walk_type == locate_target) begin
                     walk_found = 1'b1;
                     found_at   = walk_hdr_at;
                     found_len  = plen;
                  end else begin
                     nxt = walk_hdr_at + plen;
                     if (nxt > POS_LIMIT) begin
                        walk_bad = 1'b1;
                     end else begin
                        walk_hdr_at = nxt;
                        walk_type   = walk_next_type;
                     end
                  end
               end
            endcase
         end
         walk_pos = p + 1;
      end

      v.status         = STATUS_ABSENT;
      v.payload_offset = '0;
      v.payload_length = '0;
      if (!last) return 1'b0;

      if (walk_bad) begin
         v.status = STATUS_MALFORMED;
      end else if (walk_found) begin
         if (found_at + found_len > msg_len) begin
            v.status = STATUS_MALFORMED;
         end else begin
            v.status         = STATUS_FOUND;
            v.payload_offset = OFFSET_BITS'(found_at);
            v.payload_length = LENGTH_BITS'(found_len);
         end
      end else if (walk_step != HDR_WAIT) begin
         // Message ended inside a generic header.
         v.status = STATUS_MALFORMED;
      end else if (!walk_ended && walk_hdr_at != FIXED_HEADER_BYTES &&
                   walk_hdr_at > msg_len) begin
         // Last walked payload runs past the end of the message.
         v.status = STATUS_MALFORMED;
      end
      clear_walk();
      return 1'b1;
   endfunction

   initial clear_walk();

   // ------------------------------------------------------------------
   // Monitor and scoreboard: sample every port at the rising edge.
   // ------------------------------------------------------------------

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      result_type v;
      if (!reset) begin
         if (csr_valid && csr_ready) locate_target = csr_target_type;
         if (req_valid && req_ready) begin
            if (locate_byte(req_data_byte, req_last_byte, v)) begin
               // Hand-typed verdicts from the directed table override the model.
               if (row_typed) v = row_verdict;
               verdict_q.push_back(v);
            end
         end
         if (rsp_valid && rsp_ready) begin
            case (rsp_status)
               STATUS_FOUND:  cnt_found++;
               STATUS_ABSENT: cnt_absent++;
               default:       cnt_malformed++;
            endcase
            if (verdict_q.size() == 0) begin
               $error("result beat with nothing expected: status %0d offset %0d length %0d",
                      rsp_status, rsp_payload_offset, rsp_payload_length);
               mismatches++;
            end else begin
               v = verdict_q.pop_front();
               check_field("status", v.status, rsp_status);
               check_field("payload_offset", v.payload_offset, rsp_payload_offset);
               check_field("payload_length", v.payload_length, rsp_payload_length);
            end
         end
      end
   end

   // Watchdog: end the run if no beat moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $error("no beat accepted for %0d cycles", QUIET_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random stalls, plus one long hold-off on request.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_left == 0 && hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Sender helpers. Every task is entered and left at a falling edge.
   // ------------------------------------------------------------------

   // Offer one byte; hold it until the block takes the beat.
   task automatic send_byte(input logic [7:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= value;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_msg();
      foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
      msgs_sent++;
      bytes_sent += msg_bytes.size();
   endtask

   // Drop valid once the stream stops.
   task automatic sender_park();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Program the target type once the block has drained.
   task automatic write_target(input logic [TYPE_BITS-1:0] t);
      sender_park();
      while (verdict_q.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_valid       <= 1'b1;
      csr_target_type <= t;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid  <= 1'b0;
      target_now  = t;
   endtask

   // Lay out a message: random filler, first type at byte 16, then a chain
   // of generic headers from byte 28. Headers past the end are cut off.
   function automatic void build_msg(input int mlen, input int n,
                                     input logic [7:0] types [5],
                                     input logic [15:0] lens [5]);
      int unsigned h;
      logic [7:0]  hdr [4];
      msg_bytes.delete();
      for (int i = 0; i < mlen; i++) msg_bytes.push_back(8'($urandom));
      if (mlen > FIRST_TYPE_BYTE) msg_bytes[FIRST_TYPE_BYTE] = types[0];
      h = FIXED_HEADER_BYTES;
      for (int i = 0; i < n && h < mlen; i++) begin
         hdr = '{(i + 1 < n) ? types[i + 1] : TYPE_NONE, 8'($urandom),
                 lens[i][15:8], lens[i][7:0]};
         for (int k = 0; k < 4; k++) if (h + k < mlen) msg_bytes[h + k] = hdr[k];
         if (lens[i] < MIN_PAYLOAD_BYTES) break;
         h += lens[i];
      end
   endfunction

   // Mostly well-formed chains that hit the target often; the rest are
   // truncated, short-length, overrunning, short or zero-typed messages.
   function automatic void random_msg();
      int          n;
      int          mlen;
      int          k;
      int          mode;
      int          pick;
      logic [7:0]  types [5];
      logic [15:0] lens [5];
      n    = $urandom_range(4);
      mlen = FIXED_HEADER_BYTES;
      for (int i = 0; i < 5; i++) begin
         pick     = $urandom_range(99);
         types[i] = (pick < 45) ? target_now :
                    (pick < 60) ? 8'($urandom) : 8'($urandom_range(13, 1));
         lens[i]  = 16'($urandom_range(40, 4));
         if (i < n) mlen += lens[i];
      end
      if (n == 0) mlen += $urandom_range(6);
      k    = (n == 0) ? 0 : $urandom_range(n - 1);
      mode = $urandom_range(99);
      if (mode < 10)      mlen += $urandom_range(3, 1);
      else if (mode < 64) ;
      else if (mode < 74) mlen = $urandom_range(mlen - 1, 1);
      else if (mode < 80) lens[k] = 16'($urandom_range(3));
      else if (mode < 86) lens[k] = 16'($urandom_range(65535, 41));
      else if (mode < 93) mlen = $urandom_range(FIXED_HEADER_BYTES, 1);
      else                types[k] = TYPE_NONE;
      build_msg(mlen, n, types, lens);
   endfunction

   task automatic add_row(input logic [TYPE_BITS-1:0] tgt, input int mlen, input int n,
                          input logic [7:0] t0, input logic [15:0] l0,
                          input logic [7:0] t1, input logic [15:0] l1,
                          input bit typed, input status_type st,
                          input int unsigned off, input int unsigned len);
      probe_row r;
      r.tgt     = tgt;
      r.mlen    = mlen;
      r.n       = n;
      r.types   = '{t0, t1, 8'd0, 8'd0, 8'd0};
      r.lens    = '{l0, l1, 16'd0, 16'd0, 16'd0};
      r.typed   = typed;
      r.verdict = '{st, OFFSET_BITS'(off), LENGTH_BITS'(len)};
      probe_rows.push_back(r);
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : main
      logic [TYPE_BITS-1:0] tgt;
      int                   start_bytes;
      int                   start_msgs;

      // Directed table: target, length, payload count, (type, length) x2,
      // typed verdict where it is plain from the layout.
      add_row(8'd5,   20, 0, 8'd5,   16'd0,      8'd0, 16'd0, 1, STATUS_ABSENT,    0, 0);
      add_row(8'd5,    1, 0, 8'd0,   16'd0,      8'd0, 16'd0, 1, STATUS_ABSENT,    0, 0);
      add_row(8'd5,   36, 1, 8'd5,   16'd8,      8'd0, 16'd0, 1, STATUS_FOUND,    28, 8);
      add_row(8'd5,   40, 2, 8'd1,   16'd8,      8'd5, 16'd4, 0, STATUS_FOUND,     0, 0);
      add_row(8'd5,   32, 1, 8'd0,   16'd4,      8'd0, 16'd0, 1, STATUS_ABSENT,    0, 0);
      add_row(8'd5,   44, 2, 8'd1,   16'd8,      8'd0, 16'd8, 1, STATUS_ABSENT,    0, 0);
      add_row(8'd5,   36, 1, 8'd1,   16'd0,      8'd0, 16'd0, 1, STATUS_MALFORMED, 0, 0);
      add_row(8'd5,   36, 1, 8'd1,   16'd3,      8'd0, 16'd0, 1, STATUS_MALFORMED, 0, 0);
      add_row(8'd5,   30, 1, 8'd5,   16'd8,      8'd0, 16'd0, 1, STATUS_MALFORMED, 0, 0);
      add_row(8'd5,   36, 1, 8'd1,   16'd20,     8'd0, 16'd0, 0, STATUS_FOUND,     0, 0);
      add_row(8'd5,   36, 1, 8'd5,   16'hFFFF,   8'd0, 16'd0, 1, STATUS_MALFORMED, 0, 0);
      add_row(8'd8,   60, 2, 8'd1,   16'd8,      8'd8, 16'd24, 0, STATUS_FOUND,    0, 0);
      add_row(8'd0,   40, 1, 8'd1,   16'd12,     8'd0, 16'd0, 0, STATUS_FOUND,     0, 0);
      add_row(8'd255, 44, 1, 8'd255, 16'd16,     8'd0, 16'd0, 1, STATUS_FOUND,    28, 16);
      add_row(8'd255, 28, 0, 8'd7,   16'd0,      8'd0, 16'd0, 1, STATUS_ABSENT,    0, 0);
      add_row(8'd255, 40, 1, 8'd254, 16'hFFFF,   8'd0, 16'd0, 1, STATUS_MALFORMED, 0, 0);

      // Hold reset, then release it at a falling edge.
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed table at full rate.
      write_target(TARGET_RESET);
      foreach (probe_rows[i]) begin
         if (probe_rows[i].tgt != target_now) write_target(probe_rows[i].tgt);
         row_typed   = probe_rows[i].typed;
         row_verdict = probe_rows[i].verdict;
         build_msg(probe_rows[i].mlen, probe_rows[i].n, probe_rows[i].types,
                   probe_rows[i].lens);
         send_msg();
      end
      row_typed = 1'b0;

      // Random phases: new target each time, rotating through idle patterns.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0:       tgt = 8'd5;
            1:       tgt = 8'd8;
            2:       tgt = 8'd255;
            3:       tgt = 8'd0;
            default: tgt = 8'($urandom);
         endcase
         write_target(tgt);
         case (ph % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 60; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 60; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         // Back up the result side while bytes keep coming, so input stalls.
         if (ph == 0) hold_req = 1'b1;
         start_bytes = bytes_sent;
         start_msgs  = msgs_sent;
         while (bytes_sent - start_bytes < PHASE_BYTES || msgs_sent - start_msgs < PHASE_MSGS)
         begin
            random_msg();
            send_msg();
         end
      end

      // Drain: wait for every owed verdict, then a final drain wait.
      sender_park();
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d messages (%0d bytes) over directed and random runs,",
               msgs_sent, bytes_sent);
      $display("verdicts seen: %0d found, %0d absent, %0d malformed; %0d mismatches.",
               cnt_found, cnt_absent, cnt_malformed, mismatches);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
